// File: src/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg - register machine execute package
// Opcodes, widths, cost constants and the execute result bundle.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int WORD_W     = 64;
    localparam int PC_W       = 16;
    localparam int PLEN_W     = 17;
    localparam int COST_W     = 63;
    localparam int STEP_W     = 8;

    localparam logic [STEP_W-1:0] COST_MEM = 8'd50;
    localparam logic [STEP_W-1:0] COST_ALU = 8'd5;
    localparam logic [STEP_W-1:0] COST_ONE = 8'd1;
    localparam logic [STEP_W-1:0] COST_IO  = 8'd100;

    typedef enum logic [4:0] {
        OP_READ  = 5'd0,
        OP_WRITE = 5'd1,
        OP_LOAD  = 5'd2,
        OP_STORE = 5'd3,
        OP_ADD   = 5'd4,
        OP_SUB   = 5'd5,
        OP_GET   = 5'd6,
        OP_PUT   = 5'd7,
        OP_RST   = 5'd8,
        OP_INC   = 5'd9,
        OP_DEC   = 5'd10,
        OP_SHL   = 5'd11,
        OP_SHR   = 5'd12,
        OP_JUMP  = 5'd13,
        OP_JPOS  = 5'd14,
        OP_JZERO = 5'd15,
        OP_STRK  = 5'd16,
        OP_JUMPR = 5'd17,
        OP_HALT  = 5'd18
    } op_t;

    // Decisions of the execute logic for the instruction in the input register
    typedef struct packed {
        logic                 reg_we;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [WORD_W-1:0]    reg_wdata;
        logic                 mem_rd;
        logic                 mem_we;
        logic                 wr_valid;
        logic                 halt;
        logic                 fault;
        logic [PC_W-1:0]      pc_next;
        logic [STEP_W-1:0]    exec_cost;
        logic [STEP_W-1:0]    io_cost;
    } exec_res_t;

    // Saturating add of a small step onto a 63-bit running total
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [STEP_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + (COST_W+1)'(b);
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

endpackage

// File: src/rme_ram.sv
// ----------------------------------------------------------------------------
// rme_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/rme_exec.sv
// ----------------------------------------------------------------------------
// rme_exec - instruction execute logic
// Decodes one instruction against the architectural state and returns the
// register write, memory access, next pc, costs and stop condition.
// ----------------------------------------------------------------------------
module rme_exec #(
    parameter int MEM_WORDS = 4096
) (
    input  logic [4:0]                  func,
    input  logic [15:0]                 operand,
    input  logic [63:0]                 read_value,
    input  logic [rme_pkg::WORD_W-1:0]  acc,
    input  logic [rme_pkg::WORD_W-1:0]  rx,
    input  logic [rme_pkg::PC_W-1:0]    pc,
    input  logic                        stopped,
    input  logic [rme_pkg::PLEN_W-1:0]  limit,
    input  logic [rme_pkg::WORD_W-1:0]  mem_rdata,
    output rme_pkg::exec_res_t          res
);
    import rme_pkg::*;

    logic [WORD_W-1:0]    np;
    logic                 mem_ok;
    logic                 mem_bad;
    logic [REG_IDX_W-1:0] x;

    assign x      = operand[REG_IDX_W-1:0];
    assign mem_ok = rx < WORD_W'(MEM_WORDS);

    always_comb
    begin
        res       = '0;
        res.reg_idx = x;
        mem_bad   = 1'b0;
        np        = WORD_W'(pc);
        if (!stopped)
        begin
            np = WORD_W'(pc) + WORD_W'(1);
            unique case (func)
                OP_READ:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_idx   = '0;
                    res.reg_wdata = read_value;
                    res.io_cost   = COST_IO;
                end
                OP_WRITE:
                begin
                    res.wr_valid = 1'b1;
                    res.io_cost  = COST_IO;
                end
                OP_LOAD:
                begin
                    if (mem_ok)
                    begin
                        res.mem_rd    = 1'b1;
                        res.reg_we    = 1'b1;
                        res.reg_idx   = '0;
                        res.reg_wdata = mem_rdata;
                        res.exec_cost = COST_MEM;
                    end
                    else
                    begin
                        mem_bad = 1'b1;
                    end
                end
                OP_STORE:
                begin
                    if (mem_ok)
                    begin
                        res.mem_we    = 1'b1;
                        res.exec_cost = COST_MEM;
                    end
                    else
                    begin
                        mem_bad = 1'b1;
                    end
                end
                OP_ADD:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_idx   = '0;
                    res.reg_wdata = acc + rx;
                    res.exec_cost = COST_ALU;
                end
                OP_SUB:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_idx   = '0;
                    res.reg_wdata = ($signed(rx) > $signed(acc)) ? '0 : acc - rx;
                    res.exec_cost = COST_ALU;
                end
                OP_GET:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_idx   = '0;
                    res.reg_wdata = rx;
                    res.exec_cost = COST_ONE;
                end
                OP_PUT:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_wdata = acc;
                    res.exec_cost = COST_ONE;
                end
                OP_RST:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_wdata = '0;
                    res.exec_cost = COST_ONE;
                end
                OP_INC:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_wdata = rx + WORD_W'(1);
                    res.exec_cost = COST_ONE;
                end
                OP_DEC:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_wdata = ($signed(rx) > 0) ? rx - WORD_W'(1) : rx;
                    res.exec_cost = COST_ONE;
                end
                OP_SHL:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_wdata = {rx[WORD_W-2:0], 1'b0};
                    res.exec_cost = COST_ONE;
                end
                OP_SHR:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_wdata = {rx[WORD_W-1], rx[WORD_W-1:1]};
                    res.exec_cost = COST_ONE;
                end
                OP_JUMP:
                begin
                    np            = WORD_W'(operand);
                    res.exec_cost = COST_ONE;
                end
                OP_JPOS:
                begin
                    if ($signed(acc) > 0)
                    begin
                        np = WORD_W'(operand);
                    end
                    res.exec_cost = COST_ONE;
                end
                OP_JZERO:
                begin
                    if (acc == '0)
                    begin
                        np = WORD_W'(operand);
                    end
                    res.exec_cost = COST_ONE;
                end
                OP_STRK:
                begin
                    res.reg_we    = 1'b1;
                    res.reg_wdata = WORD_W'(pc);
                    res.exec_cost = COST_ONE;
                end
                OP_JUMPR:
                begin
                    np            = rx;
                    res.exec_cost = COST_ONE;
                end
                OP_HALT:
                begin
                    res.halt = 1'b1;
                    np       = WORD_W'(pc);
                end
                default:
                begin
                    np = WORD_W'(pc);
                end
            endcase

            if (mem_bad)
            begin
                res.fault = 1'b1;
                np        = WORD_W'(pc);
            end
            else if (!res.halt && np >= WORD_W'(limit))
            begin
                // instruction still commits and is charged; only pc holds
                res.fault = 1'b1;
                np        = WORD_W'(pc);
            end
        end
        res.pc_next = np[PC_W-1:0];
    end

endmodule

// File: src/register_machine_execute.sv
// ----------------------------------------------------------------------------
// register_machine_execute - accumulator register machine execute stage
// Executes one fetched instruction per transaction against eight 64-bit
// registers, a zero-initialized data RAM, a pc and saturating cost totals.
//
//   channel   dir  fields (lsb first)
//   s_axis    in   func[4:0] operand[20:5] read_value[84:21]
//   m_axis    out  next_pc[15:0] write_valid[16] write_value[80:17]
//                  halted[81] fault[82] total_cost[145:83] io_cost[208:146]
//   cfg       in   program_length[16:0], written when cfg_we is high
//
// One instruction per cycle while neither a load waiting on the registered read
// of the data RAM nor m_axis backpressure holds it. After reset the data RAM is
// cleared, one word a cycle, with s_axis_tready low until the last word is
// written. The input and the output register each hold one transaction.
// ----------------------------------------------------------------------------
module register_machine_execute #(
    parameter int MEM_WORDS  = 4096,
    parameter int PROG_DEPTH = 65536
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,   // func, operand, read_value, zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [215:0] m_axis_tdata,   // next_pc, write_valid, write_value,
                                         // halted, fault, total_cost, io_cost, pad
    input  logic         cfg_we,
    input  logic [16:0]  cfg_wdata       // program_length
);
    import rme_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [PLEN_W-1:0] DEPTH_LIM = PLEN_W'(PROG_DEPTH);

    // input register
    logic              in_valid_reg;
    logic [4:0]        in_func_reg;
    logic [15:0]       in_operand_reg;
    logic [WORD_W-1:0] in_rv_reg;

    // architectural state
    logic [WORD_W-1:0] regs_reg [NUM_REGS];
    logic [PC_W-1:0]   pc_reg;
    logic [COST_W-1:0] cost_reg, io_reg, total_reg;
    logic [COST_W-1:0] cost_next, io_next, total_next;
    logic              stopped_reg, halt_seen_reg, fault_seen_reg;
    logic              halt_seen_next, fault_seen_next;
    logic [PLEN_W-1:0] plen_reg;
    logic              load_wait_reg;

    // clearing pass
    logic              clr_active_reg;
    logic [AW-1:0]     clr_addr_reg;

    // output register
    logic              out_valid_reg;
    logic [PC_W-1:0]   out_pc_reg;
    logic              out_wvalid_reg;
    logic [WORD_W-1:0] out_wvalue_reg;
    logic              out_halted_reg, out_fault_reg;
    logic [COST_W-1:0] out_total_reg, out_io_reg;

    logic [WORD_W-1:0] rx;
    logic [WORD_W-1:0] mem_rdata;
    logic [PLEN_W-1:0] limit;
    exec_res_t         ex;
    logic              out_free, load_issue, advance, in_take;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;

    assign rx    = regs_reg[in_operand_reg[REG_IDX_W-1:0]];
    assign limit = (plen_reg < DEPTH_LIM) ? plen_reg : DEPTH_LIM;

    rme_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .func       (in_func_reg),
        .operand    (in_operand_reg),
        .read_value (in_rv_reg),
        .acc        (regs_reg[0]),
        .rx         (rx),
        .pc         (pc_reg),
        .stopped    (stopped_reg),
        .limit      (limit),
        .mem_rdata  (mem_rdata),
        .res        (ex)
    );

    // data RAM; the read port follows the register named by the operand every cycle
    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = advance && ex.mem_we;
            ram_waddr = rx[AW-1:0];
            ram_wdata = regs_reg[0];
        end
    end

    rme_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rx[AW-1:0]),
        .rdata (mem_rdata)
    );

    // handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign load_issue    = in_valid_reg && ex.mem_rd && !load_wait_reg;
    assign advance       = in_valid_reg && out_free && !load_issue;
    assign s_axis_tready = !clr_active_reg && (!in_valid_reg || advance);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign cost_next       = sat_add(cost_reg, ex.exec_cost);
    assign io_next         = sat_add(io_reg, ex.io_cost);
    assign total_next      = sat_add(total_reg, ex.exec_cost + ex.io_cost);
    assign halt_seen_next  = halt_seen_reg || ex.halt;
    assign fault_seen_next = fault_seen_reg || ex.fault;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            load_wait_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            plen_reg       <= PLEN_W'(65536);
            pc_reg         <= '0;
            cost_reg       <= '0;
            io_reg         <= '0;
            total_reg      <= '0;
            stopped_reg    <= 1'b0;
            halt_seen_reg  <= 1'b0;
            fault_seen_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MEM_WORDS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            if (cfg_we)
            begin
                plen_reg <= cfg_wdata;
            end

            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (load_issue)
            begin
                load_wait_reg <= 1'b1;
            end
            else if (advance)
            begin
                load_wait_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (ex.reg_we)
                begin
                    regs_reg[ex.reg_idx] <= ex.reg_wdata;
                end
                pc_reg         <= ex.pc_next;
                cost_reg       <= cost_next;
                io_reg         <= io_next;
                total_reg      <= total_next;
                stopped_reg    <= stopped_reg || ex.halt || ex.fault;
                halt_seen_reg  <= halt_seen_next;
                fault_seen_reg <= fault_seen_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg    <= s_axis_tdata[4:0];
            in_operand_reg <= s_axis_tdata[20:5];
            in_rv_reg      <= s_axis_tdata[84:21];
        end
        if (advance)
        begin
            out_pc_reg     <= ex.pc_next;
            out_wvalid_reg <= ex.wr_valid;
            out_wvalue_reg <= ex.wr_valid ? regs_reg[0] : '0;
            out_halted_reg <= halt_seen_next;
            out_fault_reg  <= fault_seen_next;
            out_total_reg  <= total_next;
            out_io_reg     <= io_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_io_reg, out_total_reg, out_fault_reg,
                            out_halted_reg, out_wvalue_reg, out_wvalid_reg, out_pc_reg};

`ifndef SYNTH
    a_load_wait_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        load_wait_reg |-> in_valid_reg)
        else $error("load wait without an instruction");

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s_axis_tready)
        else $error("input ready while clearing data RAM");

    a_pc_frozen_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> $stable(pc_reg))
        else $error("pc moved after stop");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_seen_reg |=> fault_seen_reg)
        else $error("fault flag cleared");
`endif

endmodule

// File: verif/register_machine_execute_tb.sv
// ----------------------------------------------------------------------------
// register_machine_execute_tb - self-checking bench for the execute stage
// Drives instruction transactions on s_axis and predicts every m_axis result
// with a cycle-free model of the machine: registers, data RAM, pc, costs and
// the sticky halt/fault flags. Runs a directed opener, random programs under
// several idle mixes and program lengths, a long output stall, and ends with
// one halt or fault followed by traffic to the stopped machine.
// ----------------------------------------------------------------------------
module register_machine_execute_tb;
    import rme_pkg::*;

    localparam int MEM_WORDS   = 4096;
    localparam int PROG_DEPTH  = 65536;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    localparam logic [4:0] OP_FIRST_UNUSED = 5'd19;
    localparam logic [4:0] OP_LAST_UNUSED  = 5'd31;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic [15:0]       operand;
        logic [4:0]        func;
    } instr_t;

    typedef struct packed {
        logic [COST_W-1:0] io_cost;
        logic [COST_W-1:0] total_cost;
        logic              fault;
        logic              halted;
        logic [WORD_W-1:0] write_value;
        logic              write_valid;
        logic [PC_W-1:0]   next_pc;
    } result_t;

    logic         clk;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata  = '0;   // func, operand, read_value, pad
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [215:0] m_axis_tdata;         // next_pc .. io_cost, pad
    logic         cfg_we        = 1'b0;
    logic [16:0]  cfg_wdata     = '0;   // program_length

    // machine state as the bench sees it
    logic [WORD_W-1:0] regs_m [NUM_REGS];
    logic [WORD_W-1:0] mem_m  [MEM_WORDS];
    logic [PC_W-1:0]   pc_m;
    logic [COST_W-1:0] exec_total;
    logic [COST_W-1:0] io_total;
    logic              stopped_m;
    logic              halt_m;
    logic              fault_m;
    logic [PLEN_W-1:0] prog_len;

    result_t expected_results [$];
    result_t got_result;
    result_t want_result;

    int mismatches    = 0;
    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int hold_cycles   = 0;
    int quiet_cycles  = 0;

    register_machine_execute #(
        .MEM_WORDS (MEM_WORDS),
        .PROG_DEPTH(PROG_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [PLEN_W-1:0] fetch_limit();
        return (prog_len < PROG_DEPTH) ? prog_len : PLEN_W'(PROG_DEPTH);
    endfunction

    // pc the instruction would move to, before any range check
    function automatic logic [63:0] next_fetch_addr(logic [4:0] func, logic [15:0] operand);
        logic [2:0]  x;
        logic [63:0] seq;
        x   = operand[2:0];
        seq = 64'(pc_m) + 64'd1;
        case (func)
            OP_JUMP:  return 64'(operand);
            OP_JPOS:  return ($signed(regs_m[0]) > 64'sd0) ? 64'(operand) : seq;
            OP_JZERO: return (regs_m[0] == '0) ? 64'(operand) : seq;
            OP_JUMPR: return regs_m[x];
            OP_HALT:  return 64'(pc_m);
            default:  return (func > OP_HALT) ? 64'(pc_m) : seq;
        endcase
    endfunction

    // negative addresses read as unsigned are huge, so one compare covers both
    function automatic bit addr_bad(logic [4:0] func, logic [2:0] x);
        return (func == OP_LOAD || func == OP_STORE) && regs_m[x] >= MEM_WORDS;
    endfunction

    function automatic bit instr_stops(instr_t it);
        if (it.func == OP_HALT || addr_bad(it.func, it.operand[2:0]))
            return 1'b1;
        return next_fetch_addr(it.func, it.operand) >= fetch_limit();
    endfunction

    function automatic logic [COST_W-1:0] cost_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

    function automatic result_t execute_instr(instr_t it);
        result_t           r;
        logic [2:0]        x;
        logic [63:0]       np;
        logic [STEP_W-1:0] exec_step;
        logic [STEP_W-1:0] io_step;
        bit                bad;
        x = it.operand[2:0];
        r = '0;
        if (!stopped_m)
        begin
            np        = next_fetch_addr(it.func, it.operand);
            bad       = addr_bad(it.func, x);
            exec_step = COST_ONE;
            io_step   = '0;
            case (it.func)
                OP_READ:
                begin
                    regs_m[0] = it.read_value;
                    exec_step = '0;
                    io_step   = COST_IO;
                end
                OP_WRITE:
                begin
                    r.write_valid = 1'b1;
                    r.write_value = regs_m[0];
                    exec_step     = '0;
                    io_step       = COST_IO;
                end
                OP_LOAD:
                begin
                    if (!bad)
                        regs_m[0] = mem_m[regs_m[x]];
                    exec_step = COST_MEM;
                end
                OP_STORE:
                begin
                    if (!bad)
                        mem_m[regs_m[x]] = regs_m[0];
                    exec_step = COST_MEM;
                end
                OP_ADD:
                begin
                    regs_m[0] = regs_m[0] + regs_m[x];
                    exec_step = COST_ALU;
                end
                OP_SUB:
                begin
                    if ($signed(regs_m[x]) > $signed(regs_m[0]))
                        regs_m[0] = '0;
                    else
                        regs_m[0] = regs_m[0] - regs_m[x];
                    exec_step = COST_ALU;
                end
                OP_GET:   regs_m[0] = regs_m[x];
                OP_PUT:   regs_m[x] = regs_m[0];
                OP_RST:   regs_m[x] = '0;
                OP_INC:   regs_m[x] = regs_m[x] + 64'd1;
                OP_DEC:
                begin
                    if ($signed(regs_m[x]) > 64'sd0)
                        regs_m[x] = regs_m[x] - 64'd1;
                end
                OP_SHL:   regs_m[x] = {regs_m[x][62:0], 1'b0};
                OP_SHR:   regs_m[x] = {regs_m[x][63], regs_m[x][63:1]};
                OP_STRK:  regs_m[x] = 64'(pc_m);
                OP_JUMP, OP_JPOS, OP_JZERO, OP_JUMPR: ;
                OP_HALT:
                begin
                    halt_m    = 1'b1;
                    stopped_m = 1'b1;
                    exec_step = '0;
                end
                default:  exec_step = '0;
            endcase
            if (bad)
            begin
                // bad address: nothing executes, nothing is charged
                fault_m   = 1'b1;
                stopped_m = 1'b1;
            end
            else
            begin
                exec_total = cost_add(exec_total, COST_W'(exec_step));
                io_total   = cost_add(io_total, COST_W'(io_step));
                if (!stopped_m && np >= fetch_limit())
                begin
                    fault_m   = 1'b1;
                    stopped_m = 1'b1;
                end
                else if (!stopped_m)
                    pc_m = np[PC_W-1:0];
            end
        end
        r.next_pc    = pc_m;
        r.halted     = halt_m;
        r.fault      = fault_m;
        r.total_cost = cost_add(exec_total, io_total);
        r.io_cost    = io_total;
        return r;
    endfunction

    function automatic logic [63:0] pick_value();
        int unsigned r;
        logic [63:0] v;
        r = $urandom_range(99);
        v = {$urandom, $urandom};
        if (r < 40)
            v = 64'($urandom_range(MEM_WORDS - 1));
        else if (r < 50)
        begin
            case ($urandom_range(3))
                0:       v = 64'h7FFF_FFFF_FFFF_FFFF;
                1:       v = 64'h8000_0000_0000_0000;
                2:       v = '1;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    function automatic logic [4:0] pick_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)  return OP_READ;
        if (r < 14) return OP_WRITE;
        if (r < 24) return OP_LOAD;
        if (r < 34) return OP_STORE;
        if (r < 42) return OP_ADD;
        if (r < 50) return OP_SUB;
        if (r < 55) return OP_GET;
        if (r < 62) return OP_PUT;
        if (r < 67) return OP_RST;
        if (r < 74) return OP_INC;
        if (r < 79) return OP_DEC;
        if (r < 83) return OP_SHL;
        if (r < 87) return OP_SHR;
        if (r < 90) return OP_JUMP;
        if (r < 92) return OP_JPOS;
        if (r < 94) return OP_JZERO;
        if (r < 96) return OP_STRK;
        if (r < 98) return OP_JUMPR;
        return 5'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    endfunction

    // random instruction that keeps the machine running
    function automatic instr_t pick_instr();
        instr_t     it;
        logic [2:0] near [NUM_REGS];
        int         n;
        int         i;
        int         tries;
        for (tries = 0; tries < 16; tries++)
        begin
            it.func       = pick_op();
            it.operand    = 16'($urandom);
            it.read_value = pick_value();
            if (it.func == OP_LOAD || it.func == OP_STORE)
            begin
                n = 0;
                for (i = 0; i < NUM_REGS; i++)
                begin
                    if (regs_m[i] < MEM_WORDS)
                    begin
                        near[n] = 3'(i);
                        n++;
                    end
                end
                if (n == 0)
                    it.func = OP_RST;
                else
                    it.operand[2:0] = near[$urandom_range(n - 1)];
            end
            if (!instr_stops(it))
                return it;
        end
        it.func    = OP_JUMP;
        it.operand = 16'($urandom_range(fetch_limit() - 1));
        return it;
    endfunction

    // enter and leave at a falling edge; tvalid stays high for back-to-back items
    task automatic issue_instr(instr_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(execute_instr(it));
        @(negedge clk);
    endtask

    task automatic issue_op(logic [4:0] func, logic [15:0] operand, logic [63:0] value);
        instr_t it;
        it.func       = func;
        it.operand    = operand;
        it.read_value = value;
        issue_instr(it);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_prog_len(logic [PLEN_W-1:0] len);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(negedge clk);
        cfg_we    <= 1'b0;
        prog_len   = len;
    endtask

    task automatic run_random(int count, int src_pct, int dst_pct);
        int i;
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        for (i = 0; i < count; i++)
            issue_instr(pick_instr());
    endtask

    task automatic test_directed();
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        issue_op(OP_READ,  16'hFFF8, 64'h7FFF_FFFF_FFFF_FFFF);
        issue_op(OP_WRITE, 16'h0000, '0);
        issue_op(OP_PUT,   16'hFFF9, '0);
        issue_op(OP_READ,  16'h0000, 64'h8000_0000_0000_0000);
        issue_op(OP_WRITE, 16'hFFFF, '1);
        issue_op(OP_ADD,   16'h0001, '0);           // min + max wraps to -1
        issue_op(OP_PUT,   16'h0004, '0);
        issue_op(OP_DEC,   16'h0004, '0);           // negative: no decrement
        issue_op(OP_SHR,   16'h0004, '0);           // -1 stays -1
        issue_op(OP_SHL,   16'h0004, '0);
        issue_op(OP_READ,  16'h0000, 64'd3);
        issue_op(OP_PUT,   16'h0002, '0);
        issue_op(OP_READ,  16'h0000, 64'd2);
        issue_op(OP_SUB,   16'h0002, '0);           // 2 - 3 clamps to zero
        issue_op(OP_DEC,   16'h0003, '0);           // zero floor
        issue_op(OP_INC,   16'h0003, '0);
        issue_op(OP_READ,  16'h0000, 64'd7);
        issue_op(OP_SUB,   16'h0002, '0);
        issue_op(OP_STORE, 16'h0003, '0);
        issue_op(OP_READ,  16'h0000, 64'(MEM_WORDS - 1));
        issue_op(OP_PUT,   16'h0007, '0);
        issue_op(OP_STORE, 16'h0007, '0);           // top word of the RAM
        issue_op(OP_LOAD,  16'h0003, '0);
        issue_op(OP_GET,   16'h0001, '0);
        issue_op(OP_JPOS,  16'd1000, '0);
        issue_op(OP_JZERO, 16'd2000, '0);           // not taken
        issue_op(OP_RST,   16'hFFF8, '0);
        issue_op(OP_JZERO, 16'd3000, '0);
        issue_op(OP_STRK,  16'h0002, '0);
        issue_op(OP_JUMPR, 16'h0002, '0);
        issue_op(OP_JUMP,  16'hFFF0, '0);
        issue_op(OP_FIRST_UNUSED, 16'hFFFF, '1);    // unknown opcodes hold the pc
        issue_op(OP_LAST_UNUSED,  16'h0000, '0);
    endtask

    task automatic test_idle_mix();
        run_random(300, 0, 0);
        run_random(300, 64, 0);
        run_random(300, 0, 64);
        run_random(300, 10, 10);
    endtask

    task automatic test_prog_length();
        write_prog_len(17'h1FFFF);                  // clamps to the program depth
        run_random(80, 10, 10);
        write_prog_len(17'd1);
        run_random(60, 10, 10);
        write_prog_len(17'd16);
        run_random(80, 10, 10);
        write_prog_len(17'($urandom_range(65535, 17)));
        run_random(80, 10, 10);
        write_prog_len(17'(PROG_DEPTH));
        run_random(80, 10, 10);
    endtask

    task automatic test_backpressure();
        wait_drained();
        @(posedge clk);
        hold_cycles = 300;
        @(negedge clk);
        run_random(150, 0, 0);
    endtask

    // one stop event per run, picked at random, then traffic to the stopped machine
    task automatic test_stop();
        logic [PLEN_W-1:0] len;
        logic [63:0]       far;
        int unsigned       kind;
        int                i;
        len = 17'($urandom_range(4096, 16));
        write_prog_len(len);
        src_idle_pct  = 10;
        dst_stall_pct = 10;
        issue_op(OP_JUMP, 16'h0000, '0);
        far  = $urandom_range(1) ? {1'b1, 63'({$urandom, $urandom})}
                                 : 64'(MEM_WORDS) + 64'($urandom);
        kind = $urandom_range(5);
        case (kind)
            0: issue_op(OP_HALT, 16'($urandom), {$urandom, $urandom});
            1, 2:
            begin
                issue_op(OP_READ, 16'h0000, far);
                issue_op(OP_PUT, {13'($urandom), 3'd5}, '0);
                issue_op((kind == 1) ? OP_LOAD : OP_STORE, {13'($urandom), 3'd5}, '0);
            end
            3: issue_op(OP_JUMP, 16'($urandom_range(65535, len)), '0);
            4:
            begin
                issue_op(OP_READ, 16'h0000, {1'b1, 63'({$urandom, $urandom})});
                issue_op(OP_JUMPR, 16'h0000, '0);
            end
            default:
            begin
                issue_op(OP_JUMP, 16'(len - 1), '0);
                issue_op(OP_INC, 16'h0003, '0);     // runs off the end of the program
            end
        endcase
        for (i = 0; i < 12; i++)
            issue_op(5'($urandom_range(31)), 16'($urandom), {$urandom, $urandom});
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles--;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s: expected %h, actual %h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            got_result = m_axis_tdata[208:0];
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transaction: %h", got_result);
            end
            else
            begin
                want_result = expected_results.pop_front();
                check_field("next_pc",     64'(want_result.next_pc),     64'(got_result.next_pc));
                check_field("write_valid", 64'(want_result.write_valid),
                            64'(got_result.write_valid));
                check_field("write_value", want_result.write_value,      got_result.write_value);
                check_field("halted",      64'(want_result.halted),      64'(got_result.halted));
                check_field("fault",       64'(want_result.fault),       64'(got_result.fault));
                check_field("total_cost",  64'(want_result.total_cost),
                            64'(got_result.total_cost));
                check_field("io_cost",     64'(want_result.io_cost),     64'(got_result.io_cost));
            end
        end
    end

    // watchdog: ends the run after a long stretch with no transaction
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        foreach (regs_m[i])
            regs_m[i] = '0;
        foreach (mem_m[i])
            mem_m[i] = '0;
        pc_m       = '0;
        exec_total = '0;
        io_total   = '0;
        stopped_m  = 1'b0;
        halt_m     = 1'b0;
        fault_m    = 1'b0;
        prog_len   = 17'(PROG_DEPTH);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_idle_mix();
        test_prog_length();
        test_backpressure();
        test_stop();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
